// File: rtl/tsd_pkg.sv
// Shared types and constants of the transfer stream deframer.
// Used by the result channel interface and by every module of the block.
package tsd_pkg;

  localparam int CNT_W      = 63;
  localparam int WORD_W     = 64;
  localparam int MARKER_LEN = 18;
  localparam int MPOS_W     = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [2:0] CLS_COUNT    = 3'd0;
  localparam logic [2:0] CLS_TOTAL    = 3'd1;
  localparam logic [2:0] CLS_NAME     = 3'd2;
  localparam logic [2:0] CLS_NAME_END = 3'd3;
  localparam logic [2:0] CLS_SIZE     = 3'd4;
  localparam logic [2:0] CLS_PAYLOAD  = 3'd5;
  localparam logic [2:0] CLS_IGNORED  = 3'd6;

  typedef struct packed {
    logic [7:0]               byte_out;
    logic [2:0]               byte_class;
    logic                     word_done;
    logic signed [WORD_W-1:0] word_value;
    logic                     is_folder;
    logic                     is_text;
    logic                     element_end;
    logic [CNT_W-1:0]         element_count;
    logic [CNT_W-1:0]         total_count;
    logic                     format_error;
  } tsd_result_t;

  // text marker, one byte per name position
  function automatic logic [7:0] marker_char(input logic [MPOS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      5'd3:    c = 8'h44;
      5'd4:    c = 8'h55;
      5'd5:    c = 8'h4B;
      5'd6:    c = 8'h54;
      5'd7:    c = 8'h4F;
      5'd11:   c = 8'h54;
      5'd12:   c = 8'h45;
      5'd13:   c = 8'h58;
      5'd14:   c = 8'h54;
      default: c = 8'h5F;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/tsd_in_if.sv
// Input channel of the deframer: one received byte per item.
// Depends on nothing.
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       conn_start;

  modport source (output valid, rx_byte, conn_start, input ready);
  modport sink   (input valid, rx_byte, conn_start, output ready);
endinterface

// File: rtl/tsd_out_if.sv
// Result channel of the deframer: one classified byte per item.
// Depends on tsd_pkg for field widths.
interface tsd_out_if;
  import tsd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [7:0]               byte_out;
  logic [2:0]               byte_class;
  logic                     word_done;
  logic signed [WORD_W-1:0] word_value;
  logic                     is_folder;
  logic                     is_text;
  logic                     element_end;
  logic [CNT_W-1:0]         element_count;
  logic [CNT_W-1:0]         total_count;
  logic                     format_error;

  modport source (output valid, byte_out, byte_class, word_done, word_value, is_folder,
                  is_text, element_end, element_count, total_count, format_error,
                  input ready);
  modport sink   (input valid, byte_out, byte_class, word_done, word_value, is_folder,
                  is_text, element_end, element_count, total_count, format_error,
                  output ready);
endinterface

// File: rtl/tsd_parser.sv
// Parser state and per-byte classification of the deframer.
// Depends on tsd_pkg; result goes to tsd_out_reg.
module tsd_parser #(
  parameter int WORD_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic                 conn_start,
  output tsd_pkg::tsd_result_t result
);
  import tsd_pkg::*;

  localparam int         WBITS    = 8 * WORD_BYTES;
  localparam logic [2:0] LAST_POS = 3'(WORD_BYTES - 1);

  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_TOTAL = 3'd1;
  localparam logic [2:0] PH_NAME  = 3'd2;
  localparam logic [2:0] PH_SIZE  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_ERROR = 3'd5;

  localparam logic [MPOS_W-1:0] MLEN      = MPOS_W'(MARKER_LEN);
  localparam logic [MPOS_W-1:0] MLEN_OVER = MPOS_W'(MARKER_LEN + 1);

  logic [2:0]        phase, phase_next;
  logic [2:0]        byte_position, byte_position_next;
  logic [WORD_W-1:0] word_shift, word_shift_next;
  logic [CNT_W-1:0]  element_length, element_length_next;
  logic [CNT_W-1:0]  element_received, element_received_next;
  logic [CNT_W-1:0]  total_received, total_received_next;
  logic [MPOS_W-1:0] marker_position, marker_position_next;
  logic              marker_match, marker_match_next;
  logic              error_flag, error_flag_next;

  logic [2:0]        cur_phase, cur_pos;
  logic [WORD_W-1:0] cur_shift;
  logic [CNT_W-1:0]  cur_len, cur_elem, cur_total;
  logic [MPOS_W-1:0] cur_mpos;
  logic              cur_match, cur_err;

  logic [WORD_W-1:0] assembled, word_sext;
  logic              last_byte, name_marker;
  logic [CNT_W-1:0]  elem_inc, total_inc;

  always_comb begin
    // a connection start sees reset state
    cur_phase = conn_start ? PH_COUNT       : phase;
    cur_pos   = conn_start ? 3'd0           : byte_position;
    cur_shift = conn_start ? '0             : word_shift;
    cur_len   = conn_start ? {CNT_W{1'b1}}  : element_length;
    cur_elem  = conn_start ? '0             : element_received;
    cur_total = conn_start ? '0             : total_received;
    cur_mpos  = conn_start ? '0             : marker_position;
    cur_match = conn_start ? 1'b1           : marker_match;
    cur_err   = conn_start ? 1'b0           : error_flag;

    assembled = cur_shift | (WORD_W'(rx_byte) << {cur_pos, 3'b000});
    for (int i = 0; i < WORD_W; i++) begin
      word_sext[i] = (i < WBITS) ? assembled[i] : assembled[WBITS-1];
    end
    last_byte   = (cur_pos == LAST_POS);
    name_marker = cur_match && (cur_mpos == MLEN);
    elem_inc    = (cur_elem  != CNT_MAX) ? cur_elem  + 1'b1 : cur_elem;
    total_inc   = (cur_total != CNT_MAX) ? cur_total + 1'b1 : cur_total;

    phase_next            = cur_phase;
    byte_position_next    = cur_pos;
    word_shift_next       = cur_shift;
    element_length_next   = cur_len;
    element_received_next = cur_elem;
    total_received_next   = cur_total;
    marker_position_next  = cur_mpos;
    marker_match_next     = cur_match;
    error_flag_next       = cur_err;

    result             = '0;
    result.byte_out    = rx_byte;
    result.byte_class  = CLS_IGNORED;

    unique case (cur_phase)
      PH_COUNT, PH_TOTAL: begin
        result.byte_class = (cur_phase == PH_COUNT) ? CLS_COUNT : CLS_TOTAL;
        if (last_byte) begin
          result.word_done   = 1'b1;
          result.word_value  = word_sext;
          byte_position_next = 3'd0;
          word_shift_next    = '0;
          if (cur_phase == PH_COUNT) begin
            phase_next = PH_TOTAL;
          end else begin
            phase_next           = PH_NAME;
            marker_position_next = '0;
            marker_match_next    = 1'b1;
          end
        end else begin
          byte_position_next = cur_pos + 3'd1;
          word_shift_next    = assembled;
        end
      end
      PH_NAME: begin
        if (rx_byte == 8'h00) begin
          result.byte_class  = CLS_NAME_END;
          result.is_text     = name_marker;
          phase_next         = PH_SIZE;
          byte_position_next = 3'd0;
          word_shift_next    = '0;
        end else begin
          result.byte_class = CLS_NAME;
          if (cur_mpos < MLEN) begin
            if (marker_char(cur_mpos) != rx_byte) marker_match_next = 1'b0;
            marker_position_next = cur_mpos + 1'b1;
          end else begin
            marker_match_next    = 1'b0;
            marker_position_next = MLEN_OVER;
          end
        end
      end
      PH_SIZE: begin
        result.byte_class = CLS_SIZE;
        result.is_text    = name_marker;
        if (last_byte) begin
          result.word_done      = 1'b1;
          result.word_value     = word_sext;
          byte_position_next    = 3'd0;
          word_shift_next       = '0;
          element_length_next   = word_sext[CNT_W-1:0];
          element_received_next = '0;
          if (&word_sext || word_sext == '0) begin
            result.is_folder     = &word_sext;
            result.element_end   = 1'b1;
            phase_next           = PH_NAME;
            marker_position_next = '0;
            marker_match_next    = 1'b1;
          end else if (word_sext[WORD_W-1]) begin
            error_flag_next = 1'b1;
            phase_next      = PH_ERROR;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          byte_position_next = cur_pos + 3'd1;
          word_shift_next    = assembled;
        end
      end
      PH_DATA: begin
        result.byte_class     = CLS_PAYLOAD;
        result.is_text        = name_marker;
        element_received_next = elem_inc;
        total_received_next   = total_inc;
        if (elem_inc >= cur_len) begin
          result.element_end   = 1'b1;
          phase_next           = PH_NAME;
          marker_position_next = '0;
          marker_match_next    = 1'b1;
        end
      end
      default: begin
        result.byte_class = CLS_IGNORED;
      end
    endcase

    result.element_count = element_received_next;
    result.total_count   = total_received_next;
    result.format_error  = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_COUNT;
      byte_position    <= 3'd0;
      word_shift       <= '0;
      element_length   <= {CNT_W{1'b1}};
      element_received <= '0;
      total_received   <= '0;
      marker_position  <= '0;
      marker_match     <= 1'b1;
      error_flag       <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      word_shift       <= word_shift_next;
      element_length   <= element_length_next;
      element_received <= element_received_next;
      total_received   <= total_received_next;
      marker_position  <= marker_position_next;
      marker_match     <= marker_match_next;
      error_flag       <= error_flag_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LAST_POS)
    else $error("byte position past word end");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |-> error_flag)
    else $error("error phase without error flag");

  a_mpos_range: assert property (@(posedge clk) disable iff (rst)
    marker_position <= MLEN_OVER)
    else $error("marker position out of range");

  a_data_counts: assert property (@(posedge clk) disable iff (rst)
    accept && !conn_start && phase == PH_DATA |=> element_received != '0)
    else $error("payload byte not counted");

endmodule

// File: rtl/tsd_out_reg.sv
// Result register of the deframer; parts the input side from the result side.
// Depends on tsd_pkg and tsd_out_if.
module tsd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  tsd_pkg::tsd_result_t result,
  output logic                 take,
  tsd_out_if.source            res
);
  import tsd_pkg::*;

  logic        valid;
  tsd_result_t data;

  assign take = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign res.valid         = valid;
  assign res.byte_out      = data.byte_out;
  assign res.byte_class    = data.byte_class;
  assign res.word_done     = data.word_done;
  assign res.word_value    = data.word_value;
  assign res.is_folder     = data.is_folder;
  assign res.is_text       = data.is_text;
  assign res.element_end   = data.element_end;
  assign res.element_count = data.element_count;
  assign res.total_count   = data.total_count;
  assign res.format_error  = data.format_error;

endmodule

// File: rtl/transfer_stream_deframer.sv
// Transfer stream deframer: classifies a connection byte stream, one byte per item.
// A result is registered and shown in the cycle after its byte is accepted.
// Throughput: one byte per cycle; input is taken whenever the result register is
// empty or being read, so a held result stalls the input.
// Reset (synchronous, rst high) returns the parser to the count header and empties
// the result register; conn_start does the same for the parser state.
module transfer_stream_deframer #(
  parameter int WORD_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst,
  tsd_in_if.sink    rx,
  tsd_out_if.source res
);
  import tsd_pkg::*;

  tsd_result_t result;
  logic        take;
  logic        accept;

  assign rx.ready = take;
  assign accept   = rx.valid && take;

  tsd_parser #(.WORD_BYTES(WORD_BYTES)) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx.rx_byte),
    .conn_start (rx.conn_start),
    .result     (result)
  );

  tsd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .result (result),
    .take   (take),
    .res    (res)
  );

endmodule

// File: dv/tb.sv
// Testbench for transfer_stream_deframer: directed and random byte streams with a
// per-byte predictor and an in-order result checker.
// Depends on tsd_pkg, tsd_in_if, tsd_out_if and the deframer RTL.
`timescale 1ns / 1ps

module tb;
  import tsd_pkg::*;

  localparam int WORD_BYTES   = 8;
  localparam int RANDOM_ITEMS = 1600;
  localparam logic [8*MARKER_LEN-1:0] TEXT_TAG =
    144'h5F5F5F44554B544F5F5F5F544558545F5F5F;

  typedef enum logic [2:0] {
    P_COUNT, P_TOTAL, P_NAME, P_SIZE, P_DATA, P_ERROR
  } parse_phase_e;

  typedef enum int {NM_EMPTY, NM_PLAIN, NM_TEXT, NM_PREFIX, NM_LONG, NM_NEAR} name_kind_e;

  logic clk;
  logic rst;

  tsd_in_if  rx_ch ();
  tsd_out_if res_ch ();

  transfer_stream_deframer #(.WORD_BYTES(WORD_BYTES)) i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predictor state
  parse_phase_e     ph;
  logic [2:0]       word_pos;
  logic [63:0]      word_acc;
  logic [63:0]      elem_len;
  logic [CNT_W-1:0] elem_seen;
  logic [CNT_W-1:0] conn_seen;
  logic [MPOS_W-1:0] tag_pos;
  logic             tag_ok;
  logic             sticky_err;

  tsd_result_t expected_results[$];

  int mismatches   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int connections  = 0;
  int text_names   = 0;
  int folders      = 0;
  int bad_sizes    = 0;
  int in_gap_max   = 0;
  int out_gap_max  = 0;
  int rcv_wait     = 0;
  int hold_left    = 0;

  function automatic logic [7:0] tag_byte(input int idx);
    return TEXT_TAG[8*(MARKER_LEN-1-idx) +: 8];
  endfunction

  task automatic parser_reset();
    ph         = P_COUNT;
    word_pos   = '0;
    word_acc   = '0;
    elem_len   = '1;
    elem_seen  = '0;
    conn_seen  = '0;
    tag_pos    = '0;
    tag_ok     = 1'b1;
    sticky_err = 1'b0;
  endtask

  task automatic begin_name();
    ph      = P_NAME;
    tag_pos = '0;
    tag_ok  = 1'b1;
  endtask

  task automatic shift_word(input logic [7:0] b, output logic done, output logic [63:0] w);
    word_acc = word_acc | ({56'd0, b} << (8 * word_pos));
    done = (int'(word_pos) + 1 >= WORD_BYTES);
    w = '0;
    if (done) begin
      w = $signed(word_acc << (64 - 8*WORD_BYTES)) >>> (64 - 8*WORD_BYTES);
      word_acc = '0;
      word_pos = '0;
    end else begin
      word_pos = word_pos + 3'd1;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic cs, output tsd_result_t r);
    logic        done;
    logic [63:0] w;
    logic        tag_hit;
    if (cs) parser_reset();
    r = '0;
    r.byte_out = b;
    r.byte_class = CLS_IGNORED;
    tag_hit = tag_ok && (tag_pos == MARKER_LEN);
    case (ph)
      P_COUNT, P_TOTAL: begin
        r.byte_class = (ph == P_COUNT) ? CLS_COUNT : CLS_TOTAL;
        shift_word(b, done, w);
        if (done) begin
          r.word_done = 1'b1;
          r.word_value = w;
          if (ph == P_COUNT) ph = P_TOTAL;
          else begin_name();
        end
      end
      P_NAME: begin
        if (b == 8'd0) begin
          r.byte_class = CLS_NAME_END;
          r.is_text = tag_hit;
          ph = P_SIZE;
          word_pos = '0;
          word_acc = '0;
        end else begin
          r.byte_class = CLS_NAME;
          if (tag_pos < MARKER_LEN) begin
            if (tag_byte(int'(tag_pos)) != b) tag_ok = 1'b0;
            tag_pos = tag_pos + 1'b1;
          end else begin
            tag_ok = 1'b0;
            tag_pos = MPOS_W'(MARKER_LEN + 1);
          end
        end
      end
      P_SIZE: begin
        r.byte_class = CLS_SIZE;
        r.is_text = tag_hit;
        shift_word(b, done, w);
        if (done) begin
          r.word_done = 1'b1;
          r.word_value = w;
          elem_len = w;
          elem_seen = '0;
          if (w == '1) begin
            r.is_folder = 1'b1;
            r.element_end = 1'b1;
            begin_name();
          end else if (w == '0) begin
            r.element_end = 1'b1;
            elem_len = '1;
            begin_name();
          end else if (w[63]) begin
            sticky_err = 1'b1;
            ph = P_ERROR;
          end else begin
            ph = P_DATA;
          end
        end
      end
      P_DATA: begin
        r.byte_class = CLS_PAYLOAD;
        r.is_text = tag_hit;
        if (elem_seen != CNT_MAX) elem_seen = elem_seen + 1'b1;
        if (conn_seen != CNT_MAX) conn_seen = conn_seen + 1'b1;
        if ({1'b0, elem_seen} >= elem_len) begin
          r.element_end = 1'b1;
          elem_len = '1;
          begin_name();
        end
      end
      default: ;
    endcase
    r.element_count = elem_seen;
    r.total_count = conn_seen;
    r.format_error = sticky_err;
  endtask

  // sender: one item per call, returns at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic cs);
    int          gap;
    tsd_result_t want;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      rx_ch.valid = 1'b0;
    end
    @(negedge clk);
    rx_ch.valid = 1'b1;
    rx_ch.rx_byte = b;
    rx_ch.conn_start = cs;
    do @(posedge clk); while (!rx_ch.ready);
    deframe_byte(b, cs, want);
    expected_results.push_back(want);
    items_sent++;
  endtask

  task automatic send_word(input logic [63:0] w, input logic cs);
    for (int i = 0; i < WORD_BYTES; i++) send_byte(w[8*i +: 8], cs && (i == 0));
  endtask

  task automatic start_connection(input logic [63:0] count, input logic [63:0] total);
    connections++;
    send_word(count, 1'b1);
    send_word(total, 1'b0);
  endtask

  task automatic send_name(input name_kind_e kind);
    int         len;
    int         odd;
    logic [7:0] b;
    case (kind)
      NM_EMPTY: ;
      NM_TEXT: for (int i = 0; i < MARKER_LEN; i++) send_byte(tag_byte(i), 1'b0);
      NM_PREFIX: begin
        len = $urandom_range(1, MARKER_LEN - 1);
        for (int i = 0; i < len; i++) send_byte(tag_byte(i), 1'b0);
      end
      NM_LONG: begin
        for (int i = 0; i < MARKER_LEN; i++) send_byte(tag_byte(i), 1'b0);
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      NM_NEAR: begin
        odd = $urandom_range(0, MARKER_LEN - 1);
        for (int i = 0; i < MARKER_LEN; i++) begin
          b = tag_byte(i);
          if (i == odd) begin
            b = 8'($urandom_range(1, 254));
            if (b >= tag_byte(i)) b = b + 8'd1;
          end
          send_byte(b, 1'b0);
        end
      end
      default: repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(1, 255)), 1'b0);
    endcase
    send_byte(8'd0, 1'b0);
  endtask

  task automatic send_element(input name_kind_e kind, input logic [63:0] size, input int npay);
    send_name(kind);
    send_word(size, 1'b0);
    repeat (npay) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_headers_and_folder();
    in_gap_max = 0;
    out_gap_max = 0;
    start_connection(64'd0, '1);
    send_element(NM_EMPTY, 64'd0, 0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h00, 1'b0);
    send_word('1, 1'b0);
    send_element(NM_TEXT, 64'd3, 0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_name_matching();
    in_gap_max = 15;
    out_gap_max = 15;
    start_connection({$urandom, $urandom}, {$urandom, $urandom});
    send_element(NM_PREFIX, 64'd1, 1);
    send_element(NM_LONG, 64'd0, 0);
    send_element(NM_NEAR, 64'd2, 2);
    send_element(NM_TEXT, '1, 0);
    send_element(NM_EMPTY, 64'd1, 1);
  endtask

  task automatic test_bad_size_and_restart();
    in_gap_max = 3;
    out_gap_max = 3;
    start_connection(64'd5, 64'd9);
    send_element(NM_PLAIN, 64'h8000_0000_0000_0000, 0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    // restart in the error state, then again in the middle of the count word
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    start_connection({$urandom, $urandom}, {$urandom, $urandom});
    send_element(NM_PLAIN, 64'h7FFF_FFFF_FFFF_FFFF, 4);
    start_connection(64'd1, 64'd1);
    send_element(NM_TEXT, 64'hFFFF_FFFF_FFFF_FFFE, 2);
  endtask

  task automatic test_backpressure();
    in_gap_max = 0;
    out_gap_max = 0;
    start_connection(64'd1, 64'd40);
    hold_left = 300;
    send_element(NM_PLAIN, 64'd40, 40);
    wait_drained();
  endtask

  task automatic test_random_streams();
    int          goal;
    int          n;
    int          pick;
    bit          open;
    logic [63:0] size;
    name_kind_e  kind;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 24))
          send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        start_connection({$urandom, $urandom}, {$urandom, $urandom});
        n = $urandom_range(1, 6);
        open = 1'b1;
        for (int i = 0; i < n && open; i++) begin
          pick = $urandom_range(0, 11);
          case (pick)
            0, 1: kind = NM_TEXT;
            2: kind = NM_PREFIX;
            3: kind = NM_LONG;
            4: kind = NM_NEAR;
            5: kind = NM_EMPTY;
            default: kind = NM_PLAIN;
          endcase
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            send_element(kind, 64'd0, 0);
          end else if (pick < 16) begin
            send_element(kind, '1, 0);
          end else if (pick < 20) begin
            size = {1'b1, 31'($urandom), $urandom};
            if (size == '1) size[0] = 1'b0;
            send_element(kind, size, $urandom_range(0, 6));
            open = 1'b0;
          end else if (pick < 23) begin
            size = {2'b01, 30'($urandom), $urandom};
            send_element(kind, size, $urandom_range(0, 10));
            open = 1'b0;
          end else begin
            size = 64'($urandom_range(1, 16));
            send_element(kind, size, int'(size));
          end
        end
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // receiver: long hold first, then the per-item stall
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else if (rcv_wait > 0) begin
        res_ch.ready = 1'b0;
        rcv_wait--;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    tsd_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      rcv_wait = $urandom_range(0, out_gap_max);
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, byte %h class %0d", $time, res_ch.byte_out,
                 res_ch.byte_class);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("byte_out", 64'(want.byte_out), 64'(res_ch.byte_out));
        check_field("byte_class", 64'(want.byte_class), 64'(res_ch.byte_class));
        check_field("word_done", 64'(want.word_done), 64'(res_ch.word_done));
        check_field("word_value", want.word_value, res_ch.word_value);
        check_field("is_folder", 64'(want.is_folder), 64'(res_ch.is_folder));
        check_field("is_text", 64'(want.is_text), 64'(res_ch.is_text));
        check_field("element_end", 64'(want.element_end), 64'(res_ch.element_end));
        check_field("element_count", 64'(want.element_count), 64'(res_ch.element_count));
        check_field("total_count", 64'(want.total_count), 64'(res_ch.total_count));
        check_field("format_error", 64'(want.format_error), 64'(res_ch.format_error));
        if (want.is_text && want.byte_class == CLS_NAME_END) text_names++;
        if (want.is_folder) folders++;
        if (want.byte_class == CLS_SIZE && want.word_done && want.format_error) bad_sizes++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("%0t ns: run timed out with %0d results outstanding", $time,
             expected_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'd0;
    rx_ch.conn_start = 1'b0;
    parser_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_headers_and_folder();
    test_name_matching();
    test_bad_size_and_restart();
    test_backpressure();
    test_random_streams();

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("Checked %0d results over %0d connections (%0d items sent).",
             results_seen, connections, items_sent);
    $display("Saw %0d text-marker names, %0d folders and %0d bad element sizes.",
             text_names, folders, bad_sizes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
